### sv/crat_pkg.sv
// Package with the types, constants and helper functions of the complex rational unit.
package crat_pkg;

  localparam int WIDTH = 32;
  localparam int NUM_W = 32;
  localparam int DEN_W = 31;
  localparam int MAG_W = 32;
  localparam int VAL_W = 128;
  localparam int MB_W  = 64;
  localparam int CNT_W = 7;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_MUL = 1'b1;

  localparam logic [NUM_W-1:0] NUM_ONE       = NUM_W'(1);
  localparam logic [NUM_W-1:0] NUM_MINUS_ONE = '1;

  typedef enum logic [1:0] {CLS_FIN, CLS_INF, CLS_IND} cls_t;

  typedef struct packed {
    cls_t             cls;
    logic             neg;
    logic             nz;
    logic [MAG_W-1:0] n;
    logic [MAG_W-1:0] d;
  } part_t;

  typedef struct packed {
    cls_t cls;
    logic neg;
    logic nz;
  } info_t;

  typedef struct packed {
    logic  mode;
    part_t a_re;
    part_t a_im;
    part_t b_re;
    part_t b_im;
  } core_req_t;

  typedef struct packed {
    logic [NUM_W-1:0] re_num;
    logic [DEN_W-1:0] re_den;
    logic [NUM_W-1:0] im_num;
    logic [DEN_W-1:0] im_den;
    logic             indeterminate;
    logic             overflow;
  } core_rsp_t;

  typedef struct packed {
    part_t xa;
    part_t xb;
    part_t ya;
    part_t yb;
  } opsel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PART, S_MLOAD, S_MUL, S_COMB, S_COMB_REV, S_ZCHK,
    S_GCD_TWO, S_GCD_A, S_GCD_B, S_GCD_CMP, S_GCD_SUB, S_GCD_SHL,
    S_DIV, S_EMIT, S_DONE
  } state_t;

  typedef enum logic [2:0] {M_XN, M_XD, M_YN, M_YD, M_P, M_Q, M_D} mstep_t;

  localparam part_t PART_ONE = '{cls: CLS_FIN, neg: 1'b0, nz: 1'b1,
                                 n: MAG_W'(1), d: MAG_W'(1)};

  function automatic part_t parse_part(input logic [NUM_W-1:0] num,
                                       input logic [NUM_W-1:0] den);
    part_t            p;
    logic [MAG_W-1:0] nm;
    logic [MAG_W-1:0] dm;
    nm = num[NUM_W-1] ? (~num + 1'b1) : num;
    dm = den[NUM_W-1] ? (~den + 1'b1) : den;
    p.n = nm;
    p.d = dm;
    if (dm == '0) begin
      p.cls = (nm == '0) ? CLS_IND : CLS_INF;
      p.neg = num[NUM_W-1];
      p.nz  = 1'b1;
      p.d   = MAG_W'(1);
    end else begin
      p.cls = CLS_FIN;
      p.nz  = (nm != '0);
      p.neg = p.nz && (num[NUM_W-1] != den[NUM_W-1]);
    end
    return p;
  endfunction

  function automatic info_t mul_info(input part_t x, input part_t y);
    info_t r;
    r.cls = CLS_FIN;
    r.nz  = x.nz && y.nz;
    r.neg = r.nz && (x.neg != y.neg);
    if (x.cls == CLS_IND || y.cls == CLS_IND) begin
      r = '{cls: CLS_IND, neg: 1'b0, nz: 1'b0};
    end else if (x.cls == CLS_INF || y.cls == CLS_INF) begin
      if ((x.cls == CLS_FIN && !x.nz) || (y.cls == CLS_FIN && !y.nz)) begin
        r = '{cls: CLS_IND, neg: 1'b0, nz: 1'b0};
      end else begin
        r = '{cls: CLS_INF, neg: (x.neg != y.neg), nz: 1'b1};
      end
    end
    return r;
  endfunction

  function automatic info_t neg_info(input info_t x);
    info_t r;
    r = x;
    if (x.cls != CLS_IND && x.nz) begin
      r.neg = !x.neg;
    end
    return r;
  endfunction

  function automatic info_t add_info(input info_t x, input info_t y);
    info_t r;
    if (x.cls == CLS_IND || y.cls == CLS_IND) begin
      r = '{cls: CLS_IND, neg: 1'b0, nz: 1'b0};
    end else if (x.cls == CLS_INF && y.cls == CLS_INF) begin
      r = (x.neg == y.neg) ? x : '{cls: CLS_IND, neg: 1'b0, nz: 1'b0};
    end else if (x.cls == CLS_INF) begin
      r = x;
    end else if (y.cls == CLS_INF) begin
      r = y;
    end else begin
      r = '{cls: CLS_FIN, neg: 1'b0, nz: 1'b1};
    end
    return r;
  endfunction

  // An add is written as x*1 + y*1 so that both modes share one sequence.
  function automatic opsel_t select_ops(input core_req_t r, input logic part);
    opsel_t o;
    if (r.mode == REQ_ADD) begin
      o.xa = part ? r.a_im : r.a_re;
      o.xb = PART_ONE;
      o.ya = part ? r.b_im : r.b_re;
      o.yb = PART_ONE;
    end else begin
      o.xa = r.a_re;
      o.ya = r.a_im;
      o.xb = part ? r.b_im : r.b_re;
      o.yb = part ? r.b_re : r.b_im;
    end
    return o;
  endfunction

endpackage

### sv/crat_ifs.sv
// Valid/ready channel interfaces for requests and responses.
interface crat_req_if;
  import crat_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [NUM_W-1:0] a_re_num;
  logic signed [NUM_W-1:0] a_re_den;
  logic signed [NUM_W-1:0] a_im_num;
  logic signed [NUM_W-1:0] a_im_den;
  logic signed [NUM_W-1:0] b_re_num;
  logic signed [NUM_W-1:0] b_re_den;
  logic signed [NUM_W-1:0] b_im_num;
  logic signed [NUM_W-1:0] b_im_den;
  modport source (output valid, req_type, a_re_num, a_re_den, a_im_num, a_im_den,
                  b_re_num, b_re_den, b_im_num, b_im_den, input ready);
  modport sink (input valid, req_type, a_re_num, a_re_den, a_im_num, a_im_den,
                b_re_num, b_re_den, b_im_num, b_im_den, output ready);
endinterface

interface crat_rsp_if;
  import crat_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] re_num;
  logic        [DEN_W-1:0] re_den;
  logic signed [NUM_W-1:0] im_num;
  logic        [DEN_W-1:0] im_den;
  logic                    indeterminate;
  logic                    overflow;
  modport source (output valid, re_num, re_den, im_num, im_den, indeterminate, overflow,
                  input ready);
  modport sink (input valid, re_num, re_den, im_num, im_den, indeterminate, overflow,
                output ready);
endinterface

### sv/complex_rational_add_mult.sv
// Top level of the complex rational adder and multiplier.
//
//   channel  modport  direction  contents
//   req      sink     in         req_type and eight signed num/den operand parts
//   rsp      source   out        reduced re/im fractions, indeterminate, overflow
//
// One request is worked at a time; ready is high only while the sequencer is idle.
// Each finite result part takes seven shift-add multiplies, a binary gcd of shift and
// subtract steps, and two restoring divisions, all on one 128-bit adder. Infinite and
// indeterminate parts are settled in the part state without multiplies; a finite part
// that sums to zero still takes the multiplies but skips the gcd and the divisions.
// The result register frees the sequencer, so a new request is taken while a response
// waits. Reset is synchronous and clears the sequencer and the response valid.
module complex_rational_add_mult (
  input logic         clk,
  input logic         rst,
  crat_req_if.sink    req,
  crat_rsp_if.source  rsp
);
  import crat_pkg::*;

  core_req_t creq;
  core_rsp_t crsp;
  logic      core_idle;
  logic      core_rsp_valid;
  logic      start;
  logic      take;

  always_comb begin
    creq.mode = req.req_type;
    creq.a_re = parse_part(req.a_re_num, req.a_re_den);
    creq.a_im = parse_part(req.a_im_num, req.a_im_den);
    creq.b_re = parse_part(req.b_re_num, req.b_re_den);
    creq.b_im = parse_part(req.b_im_num, req.b_im_den);
  end

  assign req.ready = core_idle;
  assign start     = req.valid && core_idle;
  assign take      = core_rsp_valid && (!rsp.valid || rsp.ready);

  crat_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_in    (creq),
    .take      (take),
    .idle      (core_idle),
    .rsp_valid (core_rsp_valid),
    .rsp       (crsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.re_num        <= crsp.re_num;
      rsp.re_den        <= crsp.re_den;
      rsp.im_num        <= crsp.im_num;
      rsp.im_den        <= crsp.im_den;
      rsp.indeterminate <= crsp.indeterminate;
      rsp.overflow      <= crsp.overflow;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.indeterminate && rsp.overflow))
    else $error("indeterminate and overflow both set");

  a_flagged_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.indeterminate || rsp.overflow) |->
      rsp.re_num == '0 && rsp.re_den == '0 && rsp.im_num == '0 && rsp.im_den == '0)
    else $error("flagged response carries nonzero fields");

  a_inf_unit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.indeterminate && !rsp.overflow && rsp.re_den == '0 |->
      rsp.re_num == NUM_ONE || rsp.re_num == NUM_MINUS_ONE)
    else $error("infinite real part not normalized");

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !core_rsp_valid)
    else $error("sequencer idle while holding a result");

endmodule

### sv/crat_alu.sv
// Shared 128-bit adder/subtractor with borrow out.
module crat_alu (
  input  logic [crat_pkg::VAL_W-1:0] a,
  input  logic [crat_pkg::VAL_W-1:0] b,
  input  logic                       sub,
  output logic [crat_pkg::VAL_W-1:0] y,
  output logic                       borrow
);
  import crat_pkg::*;

  logic [VAL_W:0] s;

  assign s      = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
  assign y      = s[VAL_W-1:0];
  assign borrow = sub & s[VAL_W];

endmodule

### sv/crat_core.sv
// Sequencer and datapath: multiplies, signed sum, binary gcd and division per result part.
module crat_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  crat_pkg::core_req_t req_in,
  input  logic                take,
  output logic                idle,
  output logic                rsp_valid,
  output crat_pkg::core_rsp_t rsp
);
  import crat_pkg::*;

  state_t           state, state_next;
  core_req_t        rq;
  logic             pi;
  mstep_t           mi;
  logic [VAL_W-1:0] acc, ma;
  logic [MB_W-1:0]  mb;
  logic [MB_W-1:0]  xn, xd, yn, yd;
  logic [VAL_W-1:0] pv, qv, dv, ga, gb, dq, rr;
  logic [CNT_W-1:0] kc, cnt;
  logic             xs, ys, rs, div_d;
  logic [NUM_W-1:0] re_num, im_num;
  logic [DEN_W-1:0] re_den, im_den;
  logic             ind, ovf;

  opsel_t           ops_re, ops_im, ops;
  info_t            x_re, y_re, r_re, x_im, y_im, r_im, x_cur, y_cur, r_cur;
  logic [VAL_W-1:0] alu_a, alu_b, alu_y;
  logic             alu_sub, alu_borrow;
  logic [VAL_W-1:0] src_a;
  logic [MB_W-1:0]  src_b;
  logic [VAL_W-1:0] rsh;
  logic             qbit, fit;
  logic [NUM_W-1:0] emit_num;
  logic             wr_en;
  logic [NUM_W-1:0] wr_num;
  logic [DEN_W-1:0] wr_den;

  crat_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .y      (alu_y),
    .borrow (alu_borrow)
  );

  // Class and sign of each part, decided from the operand classes, signs and zero flags alone.
  always_comb begin
    ops_re = select_ops(rq, 1'b0);
    ops_im = select_ops(rq, 1'b1);
    x_re   = mul_info(ops_re.xa, ops_re.xb);
    y_re   = mul_info(ops_re.ya, ops_re.yb);
    if (rq.mode == REQ_MUL) begin
      y_re = neg_info(y_re);
    end
    r_re  = add_info(x_re, y_re);
    x_im  = mul_info(ops_im.xa, ops_im.xb);
    y_im  = mul_info(ops_im.ya, ops_im.yb);
    r_im  = add_info(x_im, y_im);
    ops   = pi ? ops_im : ops_re;
    x_cur = pi ? x_im : x_re;
    y_cur = pi ? y_im : y_re;
    r_cur = pi ? r_im : r_re;
  end

  always_comb begin
    unique case (mi)
      M_XN: begin src_a = VAL_W'(ops.xa.n); src_b = MB_W'(ops.xb.n); end
      M_XD: begin src_a = VAL_W'(ops.xa.d); src_b = MB_W'(ops.xb.d); end
      M_YN: begin src_a = VAL_W'(ops.ya.n); src_b = MB_W'(ops.yb.n); end
      M_YD: begin src_a = VAL_W'(ops.ya.d); src_b = MB_W'(ops.yb.d); end
      M_P:  begin src_a = VAL_W'(xn); src_b = yd; end
      M_Q:  begin src_a = VAL_W'(yn); src_b = xd; end
      M_D:  begin src_a = VAL_W'(xd); src_b = yd; end
      default: begin src_a = '0; src_b = '0; end
    endcase
  end

  assign rsh  = {rr[VAL_W-2:0], dq[VAL_W-1]};
  assign qbit = !alu_borrow;
  assign fit  = (pv[VAL_W-1:WIDTH-1] == '0 || (rs && pv == (VAL_W'(1) << (WIDTH-1))))
                && dv[VAL_W-1:WIDTH-1] == '0;
  assign emit_num = rs ? (~pv[NUM_W-1:0] + 1'b1) : pv[NUM_W-1:0];

  always_comb begin
    unique case (state)
      S_MUL:      begin alu_a = acc; alu_b = ma; alu_sub = 1'b0; end
      S_COMB:     begin alu_a = pv;  alu_b = qv; alu_sub = (xs != ys); end
      S_COMB_REV: begin alu_a = qv;  alu_b = pv; alu_sub = 1'b1; end
      S_GCD_CMP,
      S_GCD_SUB:  begin alu_a = gb;  alu_b = ga; alu_sub = 1'b1; end
      S_DIV:      begin alu_a = rsh; alu_b = ga; alu_sub = 1'b1; end
      default:    begin alu_a = acc; alu_b = ma; alu_sub = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_num     = '0;
    wr_den     = '0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_PART;
      end
      S_PART: begin
        if (r_re.cls == CLS_IND || r_im.cls == CLS_IND) begin
          state_next = S_DONE;
        end else if (r_cur.cls == CLS_INF) begin
          wr_en      = 1'b1;
          wr_num     = r_cur.neg ? NUM_MINUS_ONE : NUM_ONE;
          state_next = pi ? S_DONE : S_PART;
        end else begin
          state_next = S_MLOAD;
        end
      end
      S_MLOAD: state_next = S_MUL;
      S_MUL: begin
        if (mb == '0) state_next = (mi == M_D) ? S_COMB : S_MLOAD;
      end
      S_COMB: begin
        state_next = (alu_sub && alu_borrow) ? S_COMB_REV : S_ZCHK;
      end
      S_COMB_REV: state_next = S_ZCHK;
      S_ZCHK: begin
        if (pv == '0) begin
          wr_en      = 1'b1;
          wr_den     = DEN_W'(1);
          state_next = pi ? S_DONE : S_PART;
        end else begin
          state_next = S_GCD_TWO;
        end
      end
      S_GCD_TWO: begin
        if (ga[0] || gb[0]) state_next = S_GCD_A;
      end
      S_GCD_A: begin
        if (ga[0]) state_next = S_GCD_B;
      end
      S_GCD_B: begin
        if (gb == '0) begin
          state_next = S_GCD_SHL;
        end else if (gb[0]) begin
          state_next = S_GCD_CMP;
        end
      end
      S_GCD_CMP: state_next = S_GCD_SUB;
      S_GCD_SUB: state_next = S_GCD_B;
      S_GCD_SHL: begin
        if (kc == '0) state_next = S_DIV;
      end
      S_DIV: begin
        if (cnt == '0 && div_d) state_next = S_EMIT;
      end
      S_EMIT: begin
        wr_en      = 1'b1;
        wr_num     = emit_num;
        wr_den     = dv[DEN_W-1:0];
        state_next = pi ? S_DONE : S_PART;
      end
      S_DONE: begin
        if (take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pi <= 1'b1;
      if (pi) begin
        im_num <= wr_num;
        im_den <= wr_den;
      end else begin
        re_num <= wr_num;
        re_den <= wr_den;
      end
    end
    unique case (state)
      S_IDLE: begin
        if (start) begin
          rq  <= req_in;
          pi  <= 1'b0;
          ind <= 1'b0;
          ovf <= 1'b0;
        end
      end
      S_PART: begin
        if (r_re.cls == CLS_IND || r_im.cls == CLS_IND) begin
          ind <= 1'b1;
        end
        mi <= M_XN;
        xs <= x_cur.neg;
        ys <= y_cur.neg;
      end
      S_MLOAD: begin
        acc <= '0;
        ma  <= src_a;
        mb  <= src_b;
      end
      S_MUL: begin
        if (mb == '0) begin
          unique case (mi)
            M_XN: xn <= acc[MB_W-1:0];
            M_XD: xd <= acc[MB_W-1:0];
            M_YN: yn <= acc[MB_W-1:0];
            M_YD: yd <= acc[MB_W-1:0];
            M_P:  pv <= acc;
            M_Q:  qv <= acc;
            M_D:  dv <= acc;
            default: ;
          endcase
          mi <= mstep_t'(mi + 3'd1);
        end else begin
          if (mb[0]) acc <= alu_y;
          ma <= {ma[VAL_W-2:0], 1'b0};
          mb <= {1'b0, mb[MB_W-1:1]};
        end
      end
      S_COMB: begin
        if (!(alu_sub && alu_borrow)) begin
          pv <= alu_y;
          rs <= xs;
        end
      end
      S_COMB_REV: begin
        pv <= alu_y;
        rs <= ys;
      end
      S_ZCHK: begin
        ga <= pv;
        gb <= dv;
        kc <= '0;
      end
      S_GCD_TWO: begin
        if (!(ga[0] || gb[0])) begin
          ga <= {1'b0, ga[VAL_W-1:1]};
          gb <= {1'b0, gb[VAL_W-1:1]};
          kc <= kc + 1'b1;
        end
      end
      S_GCD_A: begin
        if (!ga[0]) ga <= {1'b0, ga[VAL_W-1:1]};
      end
      S_GCD_B: begin
        if (gb != '0 && !gb[0]) gb <= {1'b0, gb[VAL_W-1:1]};
      end
      S_GCD_CMP: begin
        // Keep the smaller value in ga before the subtract.
        if (alu_borrow) begin
          ga <= gb;
          gb <= ga;
        end
      end
      S_GCD_SUB: gb <= alu_y;
      S_GCD_SHL: begin
        if (kc != '0) begin
          ga <= {ga[VAL_W-2:0], 1'b0};
          kc <= kc - 1'b1;
        end else begin
          dq    <= pv;
          rr    <= '0;
          cnt   <= '1;
          div_d <= 1'b0;
        end
      end
      S_DIV: begin
        if (cnt == '0 && !div_d) begin
          // Numerator quotient done; the denominator goes through next.
          pv    <= {dq[VAL_W-2:0], qbit};
          dq    <= dv;
          rr    <= '0;
          cnt   <= '1;
          div_d <= 1'b1;
        end else begin
          rr  <= alu_borrow ? rsh : alu_y;
          dq  <= {dq[VAL_W-2:0], qbit};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            dv <= {dq[VAL_W-2:0], qbit};
          end
        end
      end
      S_EMIT: begin
        if (!fit) ovf <= 1'b1;
      end
      default: ;
    endcase
  end

  assign idle      = (state == S_IDLE);
  assign rsp_valid = (state == S_DONE);

  always_comb begin
    rsp = '0;
    if (ind) begin
      rsp.indeterminate = 1'b1;
    end else if (ovf) begin
      rsp.overflow = 1'b1;
    end else begin
      rsp.re_num = re_num;
      rsp.re_den = re_den;
      rsp.im_num = im_num;
      rsp.im_den = im_den;
    end
  end

endmodule
